@@ rtl/iad_pkg.sv @@
// ----------------------------------------------------------------------------
// iad_pkg: shared definitions for the integer to ascii digits converter
// widths, register indexes, divider status and the digit to character map
// ----------------------------------------------------------------------------
package iad_pkg;

  // width of the number that gets converted
  localparam int unsigned VALUE_BITS = 64;

  // quotient bits resolved per divider cycle
  localparam int unsigned DIV_STEPS  = 4;
  // dividend padded to a whole number of divider cycles
  localparam int unsigned DIV_BITS   = ((VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int unsigned DIV_CYCLES = DIV_BITS / DIV_STEPS;
  localparam int unsigned DIV_CW     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // digit store: base two gives the most digits
  localparam int unsigned MAX_DIGITS = VALUE_BITS;
  localparam int unsigned DIGIT_AW   = $clog2(MAX_DIGITS);
  localparam int unsigned DIGIT_CW   = $clog2(MAX_DIGITS + 1);

  // register and field widths
  localparam int unsigned RADIX_W    = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CHAR_W     = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPERCASE  = 2'd1;

  // commands
  localparam logic CMD_UNSIGNED = 1'b0;
  localparam logic CMD_SIGNED   = 1'b1;

  // radix constants
  localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;

  // ascii constants
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOW_F = 8'h66;
  localparam logic [CHAR_W-1:0] CASE_SHIFT = 8'd32;
  localparam logic [CHAR_W-1:0] DIGIT_NINE = 8'd9;
  localparam logic [CHAR_W-1:0] DIGIT_TEN  = 8'd10;

  // divider result handed back to the sequencer
  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quot;
    logic [RADIX_W-1:0]    rem;
  } div_res_t;

  // digit value to ascii character, letters continue past 'z' for wide radixes
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d,
                                                       input logic upper);
    logic [CHAR_W-1:0] dw;
    logic [CHAR_W-1:0] ch;
    dw = {{(CHAR_W-RADIX_W){1'b0}}, d};
    if (dw > DIGIT_NINE) begin
      ch = CHAR_LOW_A + dw - DIGIT_TEN;
    end else begin
      ch = CHAR_ZERO + dw;
    end
    if (upper && ch >= CHAR_LOW_A && ch <= CHAR_LOW_F) begin
      ch = ch - CASE_SHIFT;
    end
    return ch;
  endfunction

endpackage

@@ rtl/iad_ram.sv @@
// ----------------------------------------------------------------------------
// iad_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module iad_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/iad_divider.sv @@
// ----------------------------------------------------------------------------
// iad_divider: iterative radix divider
// restoring division of the value by a 6-bit radix, a few quotient bits a cycle
// ----------------------------------------------------------------------------
module iad_divider (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [iad_pkg::VALUE_BITS-1:0]     dividend_i,
  input  logic [iad_pkg::RADIX_W-1:0]        divisor_i,
  output iad_pkg::div_res_t                  res_o
);

  logic                             busy_q;
  logic                             done_q;
  logic [iad_pkg::DIV_CW-1:0]       cnt_q;
  logic [iad_pkg::DIV_BITS-1:0]     quo_q;
  logic [iad_pkg::DIV_BITS-1:0]     quo_d;
  logic [iad_pkg::RADIX_W-1:0]      rem_q;
  logic [iad_pkg::RADIX_W-1:0]      rem_d;
  logic [iad_pkg::RADIX_W-1:0]      div_q;

  // compare and subtract steps of one cycle
  always_comb begin
    logic [iad_pkg::RADIX_W:0] part;
    logic [iad_pkg::RADIX_W:0] dext;
    rem_d = rem_q;
    quo_d = quo_q;
    dext  = {1'b0, div_q};
    for (int i = 0; i < int'(iad_pkg::DIV_STEPS); i++) begin
      part  = {rem_d, quo_d[iad_pkg::DIV_BITS-1]};
      quo_d = {quo_d[iad_pkg::DIV_BITS-2:0], 1'b0};
      if (part >= dext) begin
        part     = part - dext;
        quo_d[0] = 1'b1;
      end
      rem_d = part[iad_pkg::RADIX_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iad_pkg::DIV_CW'(iad_pkg::DIV_CYCLES - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= iad_pkg::DIV_BITS'(dividend_i);
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q[iad_pkg::VALUE_BITS-1:0];
  assign res_o.rem  = rem_q;

endmodule

@@ rtl/integer_to_ascii_digits.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_digits: integer to ascii digit stream
// converts one value per input transfer into its digits, most significant first
// ----------------------------------------------------------------------------
//  channel   direction  fields (lowest bit first)
//  s_axis    in         tdata: value[63:0]; tuser: command
//  m_axis    out        tdata: digit_char[7:0]; tlast: last_digit
//  cfg       in         cfg_index_i selects digit_base (0) or uppercase (1)
//
//  each digit costs one pass of the 4-bit-a-cycle divider plus a handover
//  through the registered done and start strobes. each digit then leaves
//  through the digit ram in states ST_RD, ST_LOAD and ST_HOLD, where ST_HOLD
//  waits out any output stall. s_axis_tready is low from the input transfer
//  until the last digit transfer.
//  after reset: digit_base 10, uppercase 0, block idle and ready.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [63:0]                       s_axis_tdata,   // value[63:0]
  input  logic                              s_axis_tuser,   // command
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // digit_char[7:0]
  output logic                              m_axis_tlast,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [iad_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [iad_pkg::RADIX_W-1:0]       cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_LOAD,
    ST_HOLD
  } state_e;

  state_e                              state_q;
  logic [iad_pkg::RADIX_W-1:0]         digit_base_q;
  logic                                uppercase_q;
  logic [iad_pkg::VALUE_BITS-1:0]      num_q;
  logic [iad_pkg::RADIX_W-1:0]         radix_q;
  logic                                upper_q;
  logic                                start_q;
  logic [iad_pkg::DIGIT_CW-1:0]        cnt_q;
  logic [iad_pkg::DIGIT_CW-1:0]        cnt_inc;
  logic [iad_pkg::DIGIT_AW-1:0]        ptr_q;
  logic                                m_tvalid_q;
  logic [iad_pkg::CHAR_W-1:0]          m_tdata_q;
  logic                                m_tlast_q;

  logic [iad_pkg::VALUE_BITS-1:0]      in_val;
  logic [iad_pkg::VALUE_BITS-1:0]      in_mag;
  logic [iad_pkg::RADIX_W-1:0]         in_radix;
  logic                                in_upper;
  logic                                s_xfer;
  iad_pkg::div_res_t                   div_res;
  logic                                ram_we;
  logic [iad_pkg::RADIX_W-1:0]         ram_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_base_q <= iad_pkg::RADIX_RESET;
      uppercase_q  <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == iad_pkg::REG_DIGIT_BASE) begin
        digit_base_q <= cfg_data_i;
      end else if (cfg_index_i == iad_pkg::REG_UPPERCASE) begin
        uppercase_q <= cfg_data_i[0];
      end
    end
  end

  // operand preparation: magnitude for signed decimal, clamped radix otherwise
  always_comb begin
    in_val = s_axis_tdata[iad_pkg::VALUE_BITS-1:0];
    if (s_axis_tuser == iad_pkg::CMD_SIGNED) begin
      in_mag   = in_val[iad_pkg::VALUE_BITS-1] ? (~in_val + 1'b1) : in_val;
      in_radix = iad_pkg::RADIX_DECIMAL;
      in_upper = 1'b0;
    end else begin
      in_mag   = in_val;
      in_radix = (digit_base_q < iad_pkg::RADIX_MIN) ? iad_pkg::RADIX_MIN : digit_base_q;
      in_upper = uppercase_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign cnt_inc       = cnt_q + 1'b1;
  assign ram_we        = (state_q == ST_DIV) && div_res.done;

  // shared divider
  iad_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (num_q),
    .divisor_i  (radix_q),
    .res_o      (div_res)
  );

  // digit store, least significant digit at address zero
  iad_ram #(
    .WIDTH (iad_pkg::RADIX_W),
    .DEPTH (iad_pkg::MAX_DIGITS)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[iad_pkg::DIGIT_AW-1:0]),
    .wdata_i (div_res.rem),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // sequencer: divide out digits, then play them back in reverse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      start_q    <= 1'b0;
      cnt_q      <= '0;
      ptr_q      <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      m_tlast_q  <= 1'b0;
    end else begin
      start_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (s_xfer) begin
            cnt_q   <= '0;
            start_q <= 1'b1;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            cnt_q <= cnt_inc;
            if (div_res.quot == '0 ||
                cnt_inc == iad_pkg::DIGIT_CW'(iad_pkg::MAX_DIGITS)) begin
              ptr_q   <= cnt_q[iad_pkg::DIGIT_AW-1:0];
              state_q <= ST_RD;
            end else begin
              start_q <= 1'b1;
            end
          end
        end
        ST_RD: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          m_tvalid_q <= 1'b1;
          m_tdata_q  <= iad_pkg::digit_to_ascii(ram_rdata, upper_q);
          m_tlast_q  <= (ptr_q == '0);
          state_q    <= ST_HOLD;
        end
        ST_HOLD: begin
          if (m_axis_tready) begin
            m_tvalid_q <= 1'b0;
            if (m_tlast_q) begin
              state_q <= ST_IDLE;
            end else begin
              ptr_q   <= ptr_q - 1'b1;
              state_q <= ST_RD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // working operands
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      num_q   <= in_mag;
      radix_q <= in_radix;
      upper_q <= in_upper;
    end else if (state_q == ST_DIV && div_res.done) begin
      num_q <= div_res.quot;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tlast  = m_tlast_q;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: integer to ascii digits converter
// feeds numbers with unsigned and signed-decimal commands under many radix and
// letter-case settings, predicts every digit character and its last flag, and
// compares each output transfer in order while both stream sides idle at random
// ----------------------------------------------------------------------------
module testbench;

  // register indexes the block does not implement, writes to them are dropped
  localparam logic [iad_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [iad_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int RANDOM_PHASES    = 10;
  localparam int NUMBERS_PER_PHASE = 43;
  localparam int DRAIN_LIMIT      = 50000;
  localparam int SETTLE_CYCLES    = 4;
  localparam int END_MARGIN       = 100;
  localparam int HOLD_OFF_CYCLES  = 300;

  // one expected digit transfer
  typedef struct {
    logic [iad_pkg::CHAR_W-1:0] code;
    logic                       last;
  } digit_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [63:0]                   s_axis_tdata;
  logic                          s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [7:0]                    m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          cfg_we_i;
  logic [iad_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [iad_pkg::RADIX_W-1:0]   cfg_data_i;

  // mirror of the register file
  logic [iad_pkg::RADIX_W-1:0] base_setting;
  logic                        upper_setting;

  digit_t      pending_digits[$];
  bit          idle_on;
  int          hold_off_left;
  int unsigned mismatch_count;
  int unsigned numbers_sent;
  int unsigned digits_checked;
  int unsigned settings_written;

  integer_to_ascii_digits dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // value[63:0]
    .s_axis_tuser  (s_axis_tuser),   // command
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // digit_char[7:0]
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #100ms;
    $display("end of test: mismatches");
    $finish;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // digit string of one number, queued most significant first
  function automatic void predict_digits(input logic cmd, input logic [63:0] raw);
    logic [63:0]                mag;
    logic [63:0]                radix;
    logic [63:0]                rem;
    logic                       upper;
    logic [iad_pkg::CHAR_W-1:0] ch;
    logic [iad_pkg::CHAR_W-1:0] chars[$];
    digit_t                     d;
    mag = raw;
    if (cmd == iad_pkg::CMD_SIGNED) begin
      radix = 64'd10;
      upper = 1'b0;
      if (mag[63]) mag = ~mag + 64'd1;
    end else begin
      radix = (base_setting < iad_pkg::RADIX_MIN) ? 64'(iad_pkg::RADIX_MIN) :
                                                    64'(base_setting);
      upper = upper_setting;
    end
    do begin
      rem = mag % radix;
      mag = mag / radix;
      ch  = (rem > 64'd9) ? iad_pkg::CHAR_W'(iad_pkg::CHAR_LOW_A + rem - 64'd10) :
                            iad_pkg::CHAR_W'(iad_pkg::CHAR_ZERO + rem);
      if (upper && ch >= iad_pkg::CHAR_LOW_A && ch <= iad_pkg::CHAR_LOW_F)
        ch = ch - iad_pkg::CASE_SHIFT;
      chars.push_front(ch);
    end while (mag != 0 && chars.size() < iad_pkg::VALUE_BITS);
    foreach (chars[k]) begin
      d.code = chars[k];
      d.last = (k == chars.size() - 1);
      pending_digits.push_back(d);
    end
  endfunction

  // random number with a spread of digit counts and signed extremes
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      4, 5, 6, 7: v = v >> $urandom_range(1, 63);
      8: begin
        case ($urandom_range(0, 4))
          0: v = 64'd0;
          1: v = '1;
          2: v = 64'h8000_0000_0000_0000;
          3: v = 64'h7FFF_FFFF_FFFF_FFFF;
          default: v = 64'd1;
        endcase
      end
      9: v = ~(v >> $urandom_range(40, 63)) + 64'd1;
      default: ;
    endcase
    return v;
  endfunction

  // one input transfer; tvalid stays high afterwards until the next call or a drain
  task automatic send_number(input logic cmd, input logic [63:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_digits(cmd, value);
    numbers_sent++;
  endtask

  // stop offering and wait until every predicted digit has been seen
  task automatic wait_all_digits();
    int guard;
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending_digits.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_digits.size() != 0) begin
      $error("%0d expected digits never arrived", pending_digits.size());
      mismatch_count += pending_digits.size();
      pending_digits.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only called while the block is idle
  task automatic write_register(input logic [iad_pkg::CFG_IDX_W-1:0] idx,
                                input logic [iad_pkg::RADIX_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      iad_pkg::REG_DIGIT_BASE: base_setting  = data;
      iad_pkg::REG_UPPERCASE:  upper_setting = data[0];
      default: ;
    endcase
    settings_written++;
  endtask

  // output side: random stalls, long hold-off on request, in-order compare
  initial begin : digit_receiver
    int     wait_left;
    digit_t want;
    m_axis_tready = 1'b0;
    wait_left     = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_digits.size() == 0) begin
          $error("digit transfer 0x%02h with nothing expected", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = pending_digits.pop_front();
          digits_checked++;
          if (m_axis_tdata !== want.code) begin
            $error("digit_char: expected 0x%02h, got 0x%02h", want.code, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_digit: expected %0b, got %0b", want.last, m_axis_tlast);
            mismatch_count++;
          end
        end
      end
      if (hold_off_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_off_left--;
      end else if (wait_left > 0) begin
        m_axis_tready <= 1'b0;
        wait_left--;
      end else begin
        m_axis_tready <= 1'b1;
        wait_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
    end
  end

  // reset values: decimal, lower case
  task automatic test_reset_defaults();
    send_number(iad_pkg::CMD_UNSIGNED, 64'd0);
    send_number(iad_pkg::CMD_UNSIGNED, 64'd1);
    send_number(iad_pkg::CMD_UNSIGNED, 64'd12345);
    send_number(iad_pkg::CMD_UNSIGNED, '1);
    wait_all_digits();
  endtask

  // signed decimal: zero, minus one, both extremes, small magnitudes
  task automatic test_signed_decimal();
    send_number(iad_pkg::CMD_SIGNED, 64'd0);
    send_number(iad_pkg::CMD_SIGNED, '1);
    send_number(iad_pkg::CMD_SIGNED, 64'h8000_0000_0000_0000);
    send_number(iad_pkg::CMD_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF);
    send_number(iad_pkg::CMD_SIGNED, ~64'd12345 + 64'd1);
    send_number(iad_pkg::CMD_SIGNED, 64'd5);
    wait_all_digits();
  endtask

  // radix and letter case settings, including out-of-range radix and index
  task automatic test_radix_settings();
    write_register(iad_pkg::REG_DIGIT_BASE, 6'd2);
    send_number(iad_pkg::CMD_UNSIGNED, '1);
    wait_all_digits();
    write_register(iad_pkg::REG_DIGIT_BASE, 6'd16);
    send_number(iad_pkg::CMD_UNSIGNED, 64'h0123_4567_89AB_CDEF);
    wait_all_digits();
    write_register(iad_pkg::REG_UPPERCASE, 6'd1);
    send_number(iad_pkg::CMD_UNSIGNED, 64'h0123_4567_89AB_CDEF);
    // signed decimal ignores both registers
    send_number(iad_pkg::CMD_SIGNED, 64'hFFFF_FFFF_FFFF_FF00);
    wait_all_digits();
    // only a..f change case in base 36
    write_register(iad_pkg::REG_DIGIT_BASE, 6'd36);
    send_number(iad_pkg::CMD_UNSIGNED, '1);
    wait_all_digits();
    // letters run past z
    write_register(iad_pkg::REG_DIGIT_BASE, 6'd63);
    send_number(iad_pkg::CMD_UNSIGNED, '1);
    wait_all_digits();
    // radix zero and one act as two
    write_register(iad_pkg::REG_DIGIT_BASE, 6'd0);
    send_number(iad_pkg::CMD_UNSIGNED, 64'hA5);
    wait_all_digits();
    write_register(iad_pkg::REG_DIGIT_BASE, 6'd1);
    send_number(iad_pkg::CMD_UNSIGNED, 64'h5A);
    wait_all_digits();
    // unimplemented indexes leave both registers alone
    write_register(iad_pkg::REG_DIGIT_BASE, 6'd10);
    write_register(iad_pkg::REG_UPPERCASE, 6'd0);
    write_register(REG_SPARE_2, 6'd16);
    write_register(REG_SPARE_3, 6'd63);
    send_number(iad_pkg::CMD_UNSIGNED, 64'd987654321);
    wait_all_digits();
  endtask

  // random numbers under random settings, some phases without idling
  task automatic test_random_numbers();
    logic [iad_pkg::RADIX_W-1:0] base_pick;
    logic                        cmd;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 4))
            0: base_pick = 6'd0;
            1: base_pick = 6'd1;
            2: base_pick = 6'd2;
            3: base_pick = 6'd36;
            default: base_pick = 6'd63;
          endcase
        end
        1: base_pick = iad_pkg::RADIX_W'($urandom_range(37, 63));
        default: base_pick = iad_pkg::RADIX_W'($urandom_range(2, 36));
      endcase
      write_register(iad_pkg::REG_DIGIT_BASE, base_pick);
      write_register(iad_pkg::REG_UPPERCASE, iad_pkg::RADIX_W'($urandom_range(0, 63)));
      if ($urandom_range(0, 2) == 0)
        write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                       iad_pkg::RADIX_W'($urandom_range(0, 63)));
      idle_on = (phase % 4 != 3);
      for (int n = 0; n < NUMBERS_PER_PHASE; n++) begin
        cmd = ($urandom_range(0, 9) < 6) ? iad_pkg::CMD_UNSIGNED : iad_pkg::CMD_SIGNED;
        send_number(cmd, random_value());
      end
      wait_all_digits();
    end
    idle_on = 1'b1;
  endtask

  // output held off for a long stretch while numbers keep coming
  task automatic test_output_hold_off();
    write_register(iad_pkg::REG_DIGIT_BASE, 6'd10);
    idle_on       = 1'b0;
    hold_off_left = HOLD_OFF_CYCLES;
    for (int n = 0; n < 8; n++) send_number(1'($urandom_range(0, 1)), random_value());
    wait_all_digits();
    idle_on = 1'b1;
  endtask

  // sequence
  initial begin
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = iad_pkg::CMD_UNSIGNED;
    cfg_we_i         = 1'b0;
    cfg_index_i      = iad_pkg::REG_DIGIT_BASE;
    cfg_data_i       = '0;
    base_setting     = iad_pkg::RADIX_RESET;
    upper_setting    = 1'b0;
    idle_on          = 1'b1;
    hold_off_left    = 0;
    mismatch_count   = 0;
    numbers_sent     = 0;
    digits_checked   = 0;
    settings_written = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_signed_decimal();
    test_radix_settings();
    test_random_numbers();
    test_output_hold_off();

    repeat (END_MARGIN) @(posedge clk_i);
    $display("run covered %0d numbers, %0d digit transfers, %0d register writes",
             numbers_sent, digits_checked, settings_written);
    $display("radix 0 to 63 with both cases, signed extremes, long output hold-off");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
